// File: design/mfkr_pkg.sv
// ----------------------------------------------------------------------------
// mfkr_pkg: shared types and constants of the keyed multi-queue FIFO
// Holds sizing constants, operation codes, controller states and the
// control structs that travel from the controller into the cell rows.
// ----------------------------------------------------------------------------
`default_nettype none

package mfkr_pkg;

  // Sizing
  localparam int NUM_DEST = 4;
  localparam int CAPACITY = 16;

  // Field widths
  localparam int KEY_W   = 60;
  localparam int DEST_W  = 2;
  localparam int COUNT_W = 5;

  // Internal widths
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = $clog2(CAPACITY);
  localparam int DIDX_W = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;

  // Operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control of one row (one destination queue)
  typedef struct packed {
    logic             wr_en;
    logic             start;
    logic             scan;
    logic             found;
    logic [POS_W-1:0] wr_pos;
    logic [KEY_W-1:0] key;
  } row_ctrl_t;

  // Control of one cell
  typedef struct packed {
    logic             wr;
    logic             scan;
    logic             found;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/mfkr_in_if.sv
// ----------------------------------------------------------------------------
// mfkr_in_if: request channel of the keyed multi-queue FIFO
// Valid/ready channel carrying the operation, destination and key.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfkr_in_if;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [mfkr_pkg::DEST_W-1:0]  dest;
  logic [mfkr_pkg::KEY_W-1:0]   key;

  modport source (output valid, output op, output dest, output key, input ready);
  modport sink   (input valid, input op, input dest, input key, output ready);

endinterface

`default_nettype wire

// File: design/mfkr_out_if.sv
// ----------------------------------------------------------------------------
// mfkr_out_if: result channel of the keyed multi-queue FIFO
// Valid/ready channel carrying the success flag and the queue count.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfkr_out_if;

  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [mfkr_pkg::COUNT_W-1:0] count;

  modport source (output valid, output ok, output count, input ready);
  modport sink   (input valid, input ok, input count, output ready);

endinterface

`default_nettype wire

// File: design/mfkr_cell.sv
// ----------------------------------------------------------------------------
// mfkr_cell: one queue slot
// Holds one key and the scan token. Compares its key while it holds the
// token and, once the match is found, takes its right neighbor's key to
// close the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module mfkr_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire mfkr_pkg::cell_ctrl_t        ctrl_i,
  input  wire                              tok_i,
  input  wire  [mfkr_pkg::KEY_W-1:0]       right_key_i,
  output logic                             tok_o,
  output logic [mfkr_pkg::KEY_W-1:0]       key_o,
  output logic                             hit_o
);

  logic                        tok_q;
  logic [mfkr_pkg::KEY_W-1:0]  key_q;
  logic [mfkr_pkg::KEY_W-1:0]  key_d;
  logic                        shift;

  // Compare at the token position only
  assign hit_o = ctrl_i.scan & tok_q & (key_q == ctrl_i.key);

  // Close up once the match is at or before this slot
  assign shift = ctrl_i.scan & tok_q & (ctrl_i.found | hit_o);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.wr) begin
      key_d = ctrl_i.key;
    end else if (shift) begin
      key_d = right_key_i;
    end
  end

  // Advance the token every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // Hold the key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign tok_o = tok_q;
  assign key_o = key_q;

endmodule

`default_nettype wire

// File: design/mfkr_row.sv
// ----------------------------------------------------------------------------
// mfkr_row: chain of cells forming one destination queue
// Head at cell 0. Decodes the tail write, launches the scan token into
// the head cell and links each cell to its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mfkr_row (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire mfkr_pkg::row_ctrl_t  ctrl_i,
  output logic                      hit_o
);

  localparam int Cap = mfkr_pkg::CAPACITY;

  logic [Cap-1:0]                   tok;
  logic [Cap-1:0]                   hit;
  logic [Cap-1:0]                   tok_in;
  logic [mfkr_pkg::KEY_W-1:0]       keys      [Cap];
  logic [mfkr_pkg::KEY_W-1:0]       right_key [Cap];
  mfkr_pkg::cell_ctrl_t             cell_ctrl [Cap];

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    // Decode the tail slot for an append
    always_comb begin
      cell_ctrl[i].wr    = ctrl_i.wr_en & (ctrl_i.wr_pos == mfkr_pkg::POS_W'(i));
      cell_ctrl[i].scan  = ctrl_i.scan;
      cell_ctrl[i].found = ctrl_i.found;
      cell_ctrl[i].key   = ctrl_i.key;
    end

    // Link the token and keys to the neighbors
    if (i == 0) begin : g_head
      assign tok_in[i] = ctrl_i.start;
    end else begin : g_body
      assign tok_in[i] = tok[i-1] & ctrl_i.scan;
    end

    if (i == Cap - 1) begin : g_tail
      assign right_key[i] = keys[i];
    end else begin : g_link
      assign right_key[i] = keys[i+1];
    end

    mfkr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[i]),
      .tok_i       (tok_in[i]),
      .right_key_i (right_key[i]),
      .tok_o       (tok[i]),
      .key_o       (keys[i]),
      .hit_o       (hit[i])
    );
  end

  // Only the token cell can report a hit
  assign hit_o = |hit;

endmodule

`default_nettype wire

// File: design/multi_fifo_with_keyed_removal.sv
// An append goes from acceptance straight to the done state; a remove first
// scans the occupied cells of the addressed row, as the scan token walks one cell per cycle.
// Requests: one transaction at a time; a new request is taken only once the
// last result has been loaded into the output register.
// Reset: asynchronous, active low; clears all queue counts and the
// controller, key slots are left as they are.
// ----------------------------------------------------------------------------
// multi_fifo_with_keyed_removal: per-destination FIFOs with delete by key
// Keeps one queue of keys per destination as a chain of cells. Appends at
// the tail; removes the first matching key nearest the head and closes up.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_fifo_with_keyed_removal (
  input  wire         clk_i,
  input  wire         rst_ni,
  mfkr_in_if.sink     in_i,
  mfkr_out_if.source  out_o
);

  localparam int NumDest = mfkr_pkg::NUM_DEST;
  localparam int CntW    = mfkr_pkg::CNT_W;
  localparam int PosW    = mfkr_pkg::POS_W;
  localparam int DidxW   = mfkr_pkg::DIDX_W;

  mfkr_pkg::state_e              state_q, state_d;
  logic [DidxW-1:0]              dest_q, dest_d;
  logic [mfkr_pkg::KEY_W-1:0]    key_q, key_d;
  logic [PosW-1:0]               step_q, step_d;
  logic                          found_q, found_d;
  logic [CntW-1:0]               counts_q [NumDest];
  logic [CntW-1:0]               counts_d [NumDest];
  logic                          res_ok_q, res_ok_d;
  logic [mfkr_pkg::COUNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_ok_q;
  logic [mfkr_pkg::COUNT_W-1:0]  out_cnt_q;
  logic                          out_load;

  logic                          in_acc;
  logic [DidxW-1:0]              in_idx;
  logic                          dest_ok;
  logic [CntW-1:0]               cur_cnt;
  logic [CntW-1:0]               sel_cnt;
  logic [CntW-1:0]               sel_cnt_m1;
  logic                          append_en;
  logic                          start_en;
  logic                          sel_hit;
  logic [NumDest-1:0]            row_hit;
  mfkr_pkg::row_ctrl_t           row_ctrl [NumDest];

  assign in_i.ready = (state_q == mfkr_pkg::ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign in_idx     = DidxW'(in_i.dest);
  assign dest_ok    = (int'(in_i.dest) < NumDest);
  assign cur_cnt    = counts_q[in_idx];
  assign sel_cnt    = counts_q[dest_q];
  assign sel_cnt_m1 = sel_cnt - CntW'(1);
  assign sel_hit    = row_hit[dest_q];

  // Next state, queue counts and result
  always_comb begin
    state_d   = state_q;
    dest_d    = dest_q;
    key_d     = key_q;
    step_d    = step_q;
    found_d   = found_q;
    res_ok_d  = res_ok_q;
    res_cnt_d = res_cnt_q;
    append_en = 1'b0;
    start_en  = 1'b0;
    out_load  = 1'b0;
    for (int d = 0; d < NumDest; d++) begin
      counts_d[d] = counts_q[d];
    end
    case (state_q)
      mfkr_pkg::ST_IDLE: begin
        if (in_acc) begin
          dest_d  = in_idx;
          key_d   = in_i.key;
          state_d = mfkr_pkg::ST_DONE;
          if (!dest_ok) begin
            res_ok_d  = 1'b0;
            res_cnt_d = '0;
          end else if (in_i.op == mfkr_pkg::OP_APPEND) begin
            if (int'(cur_cnt) >= mfkr_pkg::CAPACITY) begin
              res_ok_d  = 1'b0;
              res_cnt_d = mfkr_pkg::COUNT_W'(cur_cnt);
            end else begin
              append_en        = 1'b1;
              counts_d[in_idx] = cur_cnt + CntW'(1);
              res_ok_d         = 1'b1;
              res_cnt_d        = mfkr_pkg::COUNT_W'(cur_cnt + CntW'(1));
            end
          end else if (cur_cnt == '0) begin
            res_ok_d  = 1'b0;
            res_cnt_d = '0;
          end else begin
            start_en = 1'b1;
            step_d   = '0;
            found_d  = 1'b0;
            state_d  = mfkr_pkg::ST_SCAN;
          end
        end
      end
      mfkr_pkg::ST_SCAN: begin
        found_d = found_q | sel_hit;
        step_d  = step_q + PosW'(1);
        if (step_q == PosW'(sel_cnt_m1)) begin
          state_d  = mfkr_pkg::ST_DONE;
          res_ok_d = found_d;
          if (found_d) begin
            counts_d[dest_q] = sel_cnt_m1;
            res_cnt_d        = mfkr_pkg::COUNT_W'(sel_cnt_m1);
          end else begin
            res_cnt_d        = mfkr_pkg::COUNT_W'(sel_cnt);
          end
        end
      end
      mfkr_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = mfkr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mfkr_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive the rows of cells
  for (genvar r = 0; r < NumDest; r++) begin : g_row
    always_comb begin
      row_ctrl[r].wr_en  = append_en & (in_idx == DidxW'(r));
      row_ctrl[r].start  = start_en & (in_idx == DidxW'(r));
      row_ctrl[r].scan   = (state_q == mfkr_pkg::ST_SCAN) & (dest_q == DidxW'(r));
      row_ctrl[r].found  = found_q;
      row_ctrl[r].wr_pos = PosW'(cur_cnt);
      row_ctrl[r].key    = (state_q == mfkr_pkg::ST_IDLE) ? in_i.key : key_q;
    end

    mfkr_row u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (row_ctrl[r]),
      .hit_o  (row_hit[r])
    );
  end

  // Output register: hold a result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfkr_pkg::ST_IDLE;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int d = 0; d < NumDest; d++) begin
        counts_q[d] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      for (int d = 0; d < NumDest; d++) begin
        counts_q[d] <= counts_d[d];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dest_q    <= dest_d;
    key_q     <= key_d;
    res_ok_q  <= res_ok_d;
    res_cnt_q <= res_cnt_d;
    if (out_load) begin
      out_ok_q  <= res_ok_q;
      out_cnt_q <= res_cnt_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.ok    = out_ok_q;
  assign out_o.count = out_cnt_q;

  // Token stays inside the occupied part of the queue
  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfkr_pkg::ST_SCAN) |->
      (int'(sel_cnt) <= mfkr_pkg::CAPACITY) && (CntW'(step_q) < sel_cnt))
    else $error("scan step beyond queue count");

  // A match found by the scan shrinks the queue by one
  a_remove_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfkr_pkg::ST_SCAN && state_d == mfkr_pkg::ST_DONE && found_d) |=>
      (counts_q[dest_q] == CntW'($past(sel_cnt) - CntW'(1))))
    else $error("remove did not shrink the queue");

  // Rows only compare while scanning
  a_hit_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|row_hit) |-> (state_q == mfkr_pkg::ST_SCAN))
    else $error("cell hit outside of a scan");

endmodule

`default_nettype wire

// File: dv/multi_fifo_with_keyed_removal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_fifo_with_keyed_removal_tb: self-checking bench of the keyed FIFO
// Drives append and remove transactions into the per-destination queues and
// mirrors every queue in the bench to predict each success flag and count.
// A short table covers the empty, full, absent-key and duplicate cases. After
// it come random transactions that favor keys actually held, so that removes
// hit at every position of the queue. Sender gaps and receiver stalls vary
// from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_fifo_with_keyed_removal_tb;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int          N_DIR        = 15;
  localparam logic [mfkr_pkg::KEY_W-1:0] KEY_ALL  = {mfkr_pkg::KEY_W{1'b1}};
  localparam logic [mfkr_pkg::KEY_W-1:0] KEY_FILL = 60'h0A5_A5A5_A5A5_A500;

  typedef struct packed {
    logic                         ok;
    logic [mfkr_pkg::COUNT_W-1:0] count;
  } status_t;

  typedef struct packed {
    logic                         op;
    logic [mfkr_pkg::DEST_W-1:0]  dest;
    logic [mfkr_pkg::KEY_W-1:0]   key;
    int                           reps;
    bit                           fixed;
    logic                         ok;
    logic [mfkr_pkg::COUNT_W-1:0] count;
  } stim_row_t;

  // Directed rows: fixed rows carry the status read off directly, the others
  // go through the queue mirror. A row with reps > 1 steps its key by one.
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{mfkr_pkg::OP_REMOVE, 2'd0, 60'h0,               1, 1'b1, 1'b0, 5'd0},
    '{mfkr_pkg::OP_APPEND, 2'd3, KEY_ALL,             1, 1'b1, 1'b1, 5'd1},
    '{mfkr_pkg::OP_APPEND, 2'd3, 60'h0,               1, 1'b1, 1'b1, 5'd2},
    '{mfkr_pkg::OP_APPEND, 2'd3, KEY_ALL,             1, 1'b1, 1'b1, 5'd3},
    '{mfkr_pkg::OP_REMOVE, 2'd3, KEY_ALL,             1, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_REMOVE, 2'd3, 60'h123456789ABCDEF, 1, 1'b1, 1'b0, 5'd2},
    '{mfkr_pkg::OP_REMOVE, 2'd3, KEY_ALL,             1, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_REMOVE, 2'd3, 60'h0,               1, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_REMOVE, 2'd3, 60'h0,               1, 1'b1, 1'b0, 5'd0},
    '{mfkr_pkg::OP_APPEND, 2'd2, KEY_FILL, mfkr_pkg::CAPACITY, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_APPEND, 2'd2, KEY_ALL, 1, 1'b1, 1'b0,
      mfkr_pkg::COUNT_W'(mfkr_pkg::CAPACITY)},
    '{mfkr_pkg::OP_REMOVE, 2'd2, KEY_FILL + 60'd7,    1, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_REMOVE, 2'd2, KEY_FILL,            1, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_REMOVE, 2'd2, KEY_FILL + 60'd15,   1, 1'b0, 1'b0, 5'd0},
    '{mfkr_pkg::OP_APPEND, 2'd0, KEY_ALL,             1, 1'b0, 1'b0, 5'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned cycle_cnt = 0;
  int          fail_cnt  = 0;
  int          tx_idle_pct;
  int          rx_stall_pct;

  // Mirror of the queues and the statuses still owed by the block
  logic [mfkr_pkg::KEY_W-1:0] dest_keys [mfkr_pkg::NUM_DEST][$];
  status_t                    pending_status [$];
  status_t                    rx_want;

  mfkr_in_if  in_if ();
  mfkr_out_if out_if ();

  multi_fifo_with_keyed_removal u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Apply one transaction to the mirror and return the status it yields
  function automatic status_t apply_queue_op(input logic op,
                                             input logic [mfkr_pkg::DEST_W-1:0] dest,
                                             input logic [mfkr_pkg::KEY_W-1:0] key);
    status_t st;
    int      hit;
    st.ok = 1'b0;
    hit   = -1;
    if (op == mfkr_pkg::OP_APPEND) begin
      if (dest_keys[dest].size() < mfkr_pkg::CAPACITY) begin
        dest_keys[dest].push_back(key);
        st.ok = 1'b1;
      end
    end else begin
      for (int i = 0; i < dest_keys[dest].size(); i++) begin
        if (hit < 0 && dest_keys[dest][i] == key) hit = i;
      end
      if (hit >= 0) begin
        dest_keys[dest].delete(hit);
        st.ok = 1'b1;
      end
    end
    st.count = mfkr_pkg::COUNT_W'(dest_keys[dest].size());
    return st;
  endfunction

  function automatic logic [mfkr_pkg::KEY_W-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[mfkr_pkg::KEY_W-1:0];
  endfunction

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic op, input logic [mfkr_pkg::DEST_W-1:0] dest,
                           input logic [mfkr_pkg::KEY_W-1:0] key, input bit fixed,
                           input status_t want);
    int      gap;
    status_t st;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.dest  <= dest;
    in_if.key   <= key;
    do @(posedge clk_i); while (!in_if.ready);
    st = apply_queue_op(op, dest, key);
    pending_status.push_back(fixed ? want : st);
  endtask

  // Drop valid and wait until every owed status has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  // Check each result transaction against the oldest owed status
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        $error("result with nothing owed: ok=%0b count=%0d", out_if.ok, out_if.count);
        fail_cnt++;
      end else begin
        rx_want = pending_status.pop_front();
        if (out_if.ok !== rx_want.ok) begin
          $error("field ok: expected %0b, actual %0b", rx_want.ok, out_if.ok);
          fail_cnt++;
        end
        if (out_if.count !== rx_want.count) begin
          $error("field count: expected %0d, actual %0d", rx_want.count, out_if.count);
          fail_cnt++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("multi_fifo_with_keyed_removal verification failed");
    $finish;
  end

  initial begin
    int                          phase_idle [4];
    int                          phase_stall [4];
    int                          append_pct;
    int                          sz;
    bit                          quiet;
    logic                        op;
    logic [mfkr_pkg::DEST_W-1:0] hot_dest;
    logic [mfkr_pkg::DEST_W-1:0] dest;
    logic [mfkr_pkg::KEY_W-1:0]  key;
    logic [mfkr_pkg::KEY_W-1:0]  key_pool [4];
    status_t                     want;

    phase_idle  = '{0, 68, 0, 19};
    phase_stall = '{0, 0, 68, 19};
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.op     = mfkr_pkg::OP_APPEND;
    in_if.dest   = '0;
    in_if.key    = '0;
    out_if.ready = 1'b0;

    // Hold reset, then release it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int r = 0; r < N_DIR; r++) begin
      want = {DIR_ROWS[r].ok, DIR_ROWS[r].count};
      for (int i = 0; i < DIR_ROWS[r].reps; i++) begin
        send_item(DIR_ROWS[r].op, DIR_ROWS[r].dest,
                  DIR_ROWS[r].key + mfkr_pkg::KEY_W'(i), DIR_ROWS[r].fixed, want);
      end
    end
    drain_results();

    // Random phases; each block picks its own mix, hot queue and key pool
    for (int ph = 0; ph < 4; ph++) begin
      for (int blk = 0; blk < 6; blk++) begin
        quiet        = (ph != 0) && ($urandom_range(3) == 0);
        tx_idle_pct  = quiet ? 0 : phase_idle[ph];
        rx_stall_pct = quiet ? 0 : phase_stall[ph];
        case ($urandom_range(2))
          0: append_pct = 25;
          1: append_pct = 50;
          default: append_pct = 80;
        endcase
        hot_dest = mfkr_pkg::DEST_W'($urandom_range(mfkr_pkg::NUM_DEST - 1));
        foreach (key_pool[k]) key_pool[k] = rand_key();
        for (int n = 0; n < 64; n++) begin
          dest = $urandom_range(1) ? hot_dest
                                   : mfkr_pkg::DEST_W'($urandom_range(mfkr_pkg::NUM_DEST - 1));
          sz   = dest_keys[dest].size();
          if ($urandom_range(99) < append_pct) begin
            op  = mfkr_pkg::OP_APPEND;
            key = ($urandom_range(4) == 0) ? key_pool[$urandom_range(3)] : rand_key();
          end else begin
            // Remove mostly keys that are held, at any position
            op = mfkr_pkg::OP_REMOVE;
            if (sz > 0 && $urandom_range(3) != 0) key = dest_keys[dest][$urandom_range(sz - 1)];
            else if ($urandom_range(1)) key = key_pool[$urandom_range(3)];
            else key = rand_key();
          end
          send_item(op, dest, key, 1'b0, '0);
        end
      end
      // Hold off the sender until the block has answered everything
      drain_results();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    drain_results();
    repeat (mfkr_pkg::CAPACITY + 4) @(posedge clk_i);
    if (fail_cnt == 0 && pending_status.size() == 0) begin
      $display("multi_fifo_with_keyed_removal verification clean");
    end else begin
      $display("multi_fifo_with_keyed_removal verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
